// File: hdl/uelf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uelf_pkg: shared types and codes of the exposure lifecycle controller
// Event and result words, event codes, observed-state, operation, outcome
// and action codes, status bit positions and the queue refusal error code.
// ----------------------------------------------------------------------------
package uelf_pkg;

  // Width of the wrapping generation counter.
  localparam int unsigned GEN_WIDTH = 32;

  // Error code recorded when the action queue refuses a request.
  localparam logic signed [31:0] ERR_QUEUE_REFUSED = -32'sd1;

  typedef enum logic [4:0] {
    REQ_ATTACH            = 5'd0,
    REQ_DETACH            = 5'd1,
    REQ_INSTALL_OK        = 5'd2,
    REQ_INSTALL_CLEAN     = 5'd3,
    REQ_INSTALL_AMBIG     = 5'd4,
    REQ_UNINSTALL_BEGIN   = 5'd5,
    REQ_UNINSTALL_OK      = 5'd6,
    REQ_UNINSTALL_FAIL    = 5'd7,
    REQ_FAULT_BEGIN       = 5'd8,
    REQ_FAULT_UPDATE      = 5'd9,
    REQ_FAULT_COMPLETE    = 5'd10,
    REQ_MOUNT             = 5'd11,
    REQ_UNMOUNT           = 5'd12,
    REQ_SUSPEND           = 5'd13,
    REQ_RESUME            = 5'd14,
    REQ_REL_PENDING       = 5'd15,
    REQ_REL_CLEAR         = 5'd16,
    REQ_REL_CONFIRMED     = 5'd17,
    REQ_REL_UNCERTAIN     = 5'd18,
    REQ_REL_UNCERTAIN_GEN = 5'd19,
    REQ_QUERY             = 5'd20
  } req_e;

  typedef enum logic [2:0] {
    OBS_NOT_INSTALLED = 3'd0,
    OBS_ATTACHING     = 3'd1,
    OBS_DISCONNECTED  = 3'd2,
    OBS_MOUNTED       = 3'd3,
    OBS_SUSPENDED     = 3'd4,
    OBS_DETACHING     = 3'd5
  } obs_e;

  typedef enum logic [1:0] {
    OP_INSTALL   = 2'd0,
    OP_UNINSTALL = 2'd1,
    OP_RUNTIME   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    OUT_REJECT = 2'd0,
    OUT_NOOP   = 2'd1,
    OUT_ACCEPT = 2'd2,
    OUT_NONE   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_INSTALL   = 2'd1,
    ACT_UNINSTALL = 2'd2
  } action_e;

  // Bit positions in status_bits.
  localparam int unsigned ST_EXPOSED   = 0;
  localparam int unsigned ST_SAFETY    = 1;
  localparam int unsigned ST_UNCERTAIN = 2;
  localparam int unsigned ST_RECOVERY  = 3;

  typedef struct packed {
    logic [4:0]         req_type;
    logic               queue_accepts;
    logic signed [31:0] fault_code;
    logic               driver_gone;
    logic               ep_ready;
    logic [31:0]        given_generation;
  } evt_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [1:0]         sched_action;
    logic [3:0]         status_bits;
    logic [2:0]         obs_state;
    logic [31:0]        generation_now;
    logic [31:0]        uncertain_generation;
    logic               err_valid;
    logic [1:0]         error_operation;
    logic signed [31:0] last_error_code;
    logic               hid_accepted;
    logic               prior_unresolved;
  } res_t;

endpackage

// File: hdl/uelf_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uelf_evt_if: event channel
// Valid/ready channel that carries one event word per handshake.
// ----------------------------------------------------------------------------
interface uelf_evt_if import uelf_pkg::*; ();
  logic valid;
  logic ready;
  evt_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/uelf_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uelf_res_if: result channel
// Valid/ready channel that carries one result word per handshake.
// ----------------------------------------------------------------------------
interface uelf_res_if import uelf_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/uelf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uelf_core: lifecycle state and event decode
// Holds the lifecycle registers, applies one event when fire_i is high and
// forms the result word from the updated state.
// ----------------------------------------------------------------------------
module uelf_core import uelf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  evt_t evt_i,
  output res_t res_o
);

  logic                 exposed_q, exposed_d;
  obs_e                 obs_q, obs_d;
  logic                 recovery_q, recovery_d;
  logic                 safety_q, safety_d;
  logic                 uncertain_q, uncertain_d;
  logic [GEN_WIDTH-1:0] gen_q, gen_d;
  logic [GEN_WIDTH-1:0] ugen_q, ugen_d;
  logic                 teardown_q, teardown_d;
  logic                 fault_q, fault_d;
  logic                 err_present_q, err_present_d;
  op_e                  err_op_q, err_op_d;
  logic signed [31:0]   err_code_q, err_code_d;

  outcome_e outcome;
  action_e  action;
  logic     exp_attach;
  logic     hid_detach;
  logic     bus_ok;

  always_comb begin
    exposed_d     = exposed_q;
    obs_d         = obs_q;
    recovery_d    = recovery_q;
    safety_d      = safety_q;
    uncertain_d   = uncertain_q;
    gen_d         = gen_q;
    ugen_d        = ugen_q;
    teardown_d    = teardown_q;
    fault_d       = fault_q;
    err_present_d = err_present_q;
    err_op_d      = err_op_q;
    err_code_d    = err_code_q;
    outcome       = OUT_NONE;
    action        = ACT_NONE;

    exp_attach = exposed_q && (obs_q == OBS_ATTACHING);
    hid_detach = !exposed_q && (obs_q == OBS_DETACHING);
    bus_ok     = exposed_q && !recovery_q;

    case (evt_i.req_type)
      REQ_ATTACH: begin
        if ((obs_q == OBS_DETACHING) || recovery_q) begin
          outcome = OUT_REJECT;
        end else if (obs_q != OBS_NOT_INSTALLED) begin
          outcome = exposed_q ? OUT_NOOP : OUT_REJECT;
        end else begin
          exposed_d     = 1'b1;
          obs_d         = OBS_ATTACHING;
          err_present_d = 1'b0;
          err_op_d      = OP_INSTALL;
          err_code_d    = '0;
          teardown_d    = 1'b0;
          gen_d         = gen_q + GEN_WIDTH'(1);
          if (evt_i.queue_accepts) begin
            recovery_d = 1'b0;
            outcome    = OUT_ACCEPT;
            action     = ACT_INSTALL;
          end else begin
            err_present_d = 1'b1;
            err_code_d    = ERR_QUEUE_REFUSED;
            recovery_d    = 1'b1;
            outcome       = OUT_REJECT;
          end
        end
      end
      REQ_DETACH: begin
        if (obs_q == OBS_ATTACHING) begin
          outcome = OUT_REJECT;
        end else if (!exposed_q &&
                     ((obs_q == OBS_NOT_INSTALLED) || (obs_q == OBS_DETACHING))) begin
          outcome = OUT_NOOP;
        end else if (!exposed_q || (obs_q == OBS_NOT_INSTALLED) || recovery_q) begin
          outcome = OUT_REJECT;
        end else begin
          exposed_d     = 1'b0;
          safety_d      = 1'b1;
          obs_d         = OBS_DETACHING;
          err_present_d = 1'b0;
          err_op_d      = OP_INSTALL;
          err_code_d    = '0;
          if (evt_i.queue_accepts) begin
            outcome = OUT_ACCEPT;
            action  = ACT_UNINSTALL;
          end else begin
            err_present_d = 1'b1;
            err_op_d      = OP_UNINSTALL;
            err_code_d    = ERR_QUEUE_REFUSED;
            recovery_d    = 1'b1;
            outcome       = OUT_REJECT;
          end
        end
      end
      REQ_INSTALL_OK: begin
        if (exp_attach) begin
          recovery_d = 1'b0;
          obs_d      = OBS_DISCONNECTED;
        end
      end
      REQ_INSTALL_CLEAN: begin
        if (exp_attach) begin
          err_present_d = 1'b1;
          err_op_d      = OP_INSTALL;
          err_code_d    = evt_i.fault_code;
          recovery_d    = 1'b0;
          obs_d         = OBS_NOT_INSTALLED;
        end
      end
      REQ_INSTALL_AMBIG: begin
        if (exp_attach) begin
          err_present_d = 1'b1;
          err_op_d      = OP_INSTALL;
          err_code_d    = evt_i.fault_code;
          recovery_d    = 1'b1;
        end
      end
      REQ_UNINSTALL_BEGIN: begin
        if (hid_detach && !teardown_q) begin
          teardown_d = 1'b1;
          gen_d      = gen_q + GEN_WIDTH'(1);
        end
      end
      REQ_UNINSTALL_OK: begin
        if (hid_detach) begin
          recovery_d = 1'b0;
          obs_d      = OBS_NOT_INSTALLED;
        end
      end
      REQ_UNINSTALL_FAIL: begin
        if (hid_detach) begin
          err_present_d = 1'b1;
          err_op_d      = OP_UNINSTALL;
          err_code_d    = evt_i.fault_code;
          recovery_d    = 1'b1;
        end
      end
      REQ_FAULT_BEGIN: begin
        if (fault_q) begin
          outcome = OUT_REJECT;
        end else begin
          fault_d       = 1'b1;
          err_present_d = 1'b1;
          err_op_d      = OP_RUNTIME;
          err_code_d    = evt_i.fault_code;
          teardown_d    = 1'b0;
          exposed_d     = 1'b0;
          safety_d      = 1'b1;
          obs_d         = OBS_DETACHING;
          outcome       = OUT_ACCEPT;
        end
      end
      REQ_FAULT_UPDATE: begin
        if (fault_q) begin
          err_present_d = 1'b1;
          err_op_d      = OP_RUNTIME;
          err_code_d    = evt_i.fault_code;
        end
      end
      REQ_FAULT_COMPLETE: begin
        if (fault_q) begin
          recovery_d = 1'b1;
          if (evt_i.driver_gone) begin
            obs_d = OBS_NOT_INSTALLED;
          end
        end
      end
      REQ_MOUNT: begin
        if (bus_ok && (obs_q != OBS_DETACHING)) begin
          obs_d   = OBS_MOUNTED;
          outcome = OUT_ACCEPT;
        end else begin
          outcome = OUT_REJECT;
        end
      end
      REQ_UNMOUNT: begin
        if (bus_ok && (obs_q != OBS_DETACHING)) begin
          if (obs_q != OBS_DISCONNECTED) begin
            gen_d = gen_q + GEN_WIDTH'(1);
          end
          obs_d   = OBS_DISCONNECTED;
          outcome = OUT_ACCEPT;
        end else begin
          outcome = OUT_REJECT;
        end
      end
      REQ_SUSPEND: begin
        if (bus_ok && (obs_q == OBS_MOUNTED)) begin
          obs_d   = OBS_SUSPENDED;
          outcome = OUT_ACCEPT;
        end else begin
          outcome = OUT_REJECT;
        end
      end
      REQ_RESUME: begin
        if (bus_ok && (obs_q == OBS_SUSPENDED)) begin
          obs_d   = OBS_MOUNTED;
          outcome = OUT_ACCEPT;
        end else begin
          outcome = OUT_REJECT;
        end
      end
      REQ_REL_PENDING: begin
        safety_d = 1'b1;
      end
      REQ_REL_CLEAR: begin
        if (uncertain_q) begin
          outcome = OUT_REJECT;
        end else begin
          safety_d = 1'b0;
          outcome  = OUT_ACCEPT;
        end
      end
      REQ_REL_CONFIRMED: begin
        safety_d    = 1'b0;
        uncertain_d = 1'b0;
        ugen_d      = '0;
      end
      REQ_REL_UNCERTAIN: begin
        safety_d    = 1'b1;
        uncertain_d = 1'b1;
        ugen_d      = gen_q;
      end
      REQ_REL_UNCERTAIN_GEN: begin
        safety_d    = 1'b1;
        uncertain_d = 1'b1;
        ugen_d      = GEN_WIDTH'(evt_i.given_generation);
      end
      default: begin
        // query and unused codes: report only
      end
    endcase
  end

  // Snapshot after the event.
  always_comb begin
    res_o.outcome                   = outcome;
    res_o.sched_action              = action;
    res_o.status_bits[ST_EXPOSED]   = exposed_d;
    res_o.status_bits[ST_SAFETY]    = safety_d;
    res_o.status_bits[ST_UNCERTAIN] = uncertain_d;
    res_o.status_bits[ST_RECOVERY]  = recovery_d;
    res_o.obs_state                 = obs_d;
    res_o.generation_now            = 32'(gen_d);
    res_o.uncertain_generation      = 32'(ugen_d);
    res_o.err_valid                 = err_present_d;
    res_o.error_operation           = err_op_d;
    res_o.last_error_code           = err_code_d;
    res_o.hid_accepted              = !recovery_d && exposed_d && (obs_d == OBS_MOUNTED) &&
                                      evt_i.ep_ready;
    res_o.prior_unresolved          = uncertain_d && (ugen_d != gen_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposed_q     <= 1'b0;
      obs_q         <= OBS_NOT_INSTALLED;
      recovery_q    <= 1'b0;
      safety_q      <= 1'b0;
      uncertain_q   <= 1'b0;
      gen_q         <= '0;
      ugen_q        <= '0;
      teardown_q    <= 1'b0;
      fault_q       <= 1'b0;
      err_present_q <= 1'b0;
      err_op_q      <= OP_INSTALL;
      err_code_q    <= '0;
    end else if (fire_i) begin
      exposed_q     <= exposed_d;
      obs_q         <= obs_d;
      recovery_q    <= recovery_d;
      safety_q      <= safety_d;
      uncertain_q   <= uncertain_d;
      gen_q         <= gen_d;
      ugen_q        <= ugen_d;
      teardown_q    <= teardown_d;
      fault_q       <= fault_d;
      err_present_q <= err_present_d;
      err_op_q      <= err_op_d;
      err_code_q    <= err_code_d;
    end
  end

endmodule

// File: hdl/usb_exposure_lifecycle_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_exposure_lifecycle_fsm: USB device exposure lifecycle controller
// Takes one lifecycle event per word and returns one result word with the
// outcome, the scheduled queue action and a full status snapshot.
// ----------------------------------------------------------------------------
// Every event word on evt_i produces exactly one result word on res_o, in
// order. The block takes one event per clock cycle while res_o is not
// stalled: an event lands in the input register, then the decode logic in
// uelf_core applies it to the lifecycle registers and the result is captured
// in the output register, from which it is offered on res_o. Both registers
// advance together whenever the output register is empty or its word is
// being taken, so a stalled consumer backs up the input register first and
// evt_i.ready drops only when both hold a word. The result reflects the state
// after the event, and queue refusals, ignored completions and unknown event
// codes (which act as a query) all still return a word. There are no
// configuration registers; reset clears all lifecycle state.
// ----------------------------------------------------------------------------
module usb_exposure_lifecycle_fsm import uelf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  uelf_evt_if.sink          evt_i,
  uelf_res_if.source        res_o
);

  // Input register: one event waiting for decode.
  logic in_valid_q;
  evt_t in_evt_q;

  // Output register: one finished result waiting for the consumer.
  logic res_valid_q;
  res_t res_q;

  res_t core_res;
  logic advance;
  logic fire;

  // Advance the pipe when the output slot is free or being emptied.
  assign advance     = !res_valid_q || res_o.ready;
  // Apply the held event to the lifecycle state on this edge.
  assign fire        = in_valid_q && advance;
  // Take a new word whenever the input slot empties this cycle.
  assign evt_i.ready = !in_valid_q || advance;

  uelf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .evt_i  (in_evt_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        in_valid_q <= evt_i.valid;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: load only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      in_evt_q <= evt_i.payload;
    end
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A queue action is only handed out with an accepted outcome.
  a_action_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.sched_action != ACT_NONE)) |-> (res_q.outcome == OUT_ACCEPT))
    else $error("scheduled action without accepted outcome");

  // HID acceptance requires exposed, not recovering and mounted.
  a_hid_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.hid_accepted) |->
      (res_q.status_bits[ST_EXPOSED] && !res_q.status_bits[ST_RECOVERY] &&
       (res_q.obs_state == OBS_MOUNTED)))
    else $error("hid accepted in a state that forbids it");

  // Release uncertainty always comes with safety pending.
  a_uncertain_implies_safety: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status_bits[ST_UNCERTAIN]) |-> res_q.status_bits[ST_SAFETY])
    else $error("release uncertain without safety pending");

  // Unresolved prior generation is only reported while release is uncertain.
  a_prior_needs_uncertain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.prior_unresolved) |->
      (res_q.status_bits[ST_UNCERTAIN] &&
       (res_q.uncertain_generation != res_q.generation_now)))
    else $error("prior unresolved without matching uncertainty");

  // A held event is applied in the cycle the output slot frees up.
  a_event_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !res_valid_q) |=> res_valid_q)
    else $error("held event not moved to the result register");

endmodule
